[hdl/nrbs_pkg.sv]
// Package for the nearest ray box/sphere hit unit: widths, sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package nrbs_pkg;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_OX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OZ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DZ = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RAD = 3'd6;

  typedef struct packed {
    logic        kind;
    logic [31:0] item_id;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic signed [31:0] sphere_centre_x;
    logic signed [31:0] sphere_centre_y;
    logic signed [31:0] sphere_centre_z;
    logic        last_item;
  } nrbs_in_t;

  typedef struct packed {
    logic        box_found;
    logic [30:0] box_distance;
    logic [31:0] box_id;
    logic        sphere_found;
    logic [30:0] sphere_distance;
    logic [31:0] sphere_id;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } nrbs_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_BAX, S_BDIV, S_BDIV_W, S_BNEXT, S_BDONE,
    S_SM, S_SMUL, S_SRR, S_SCHK, S_SSQ, S_SSQ_W, S_SDONE,
    S_UPD, S_PT, S_PT_W, S_OUT
  } nrbs_state_t;
endpackage
`default_nettype wire

[hdl/nrbs_if.sv]
// Valid/ready channel carrying one payload item.
// Depends on nothing; the payload type is a type parameter.
`timescale 1ns / 1ps
`default_nettype none
interface nrbs_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/nearest_ray_box_sphere_hit_unit.sv]
// Top level of the nearest ray box/sphere hit unit: sequencer, datapath, result.
// Depends on nrbs_pkg, nrbs_if, nrbs_divider, nrbs_sqrt.
//
//  channel   role    payload                         handshake
//  in_item   sink    nrbs_in_t (one primitive)       valid/ready
//  out_hit   source  nrbs_out_t (per query)          valid/ready
//  cfg       write   cfg_we, cfg_index, cfg_data     enable only
//
// A box takes up to three axes of two divisions each, and stops at a miss; a
// sphere uses the 64-step root unit. The last item of a query also forms the
// hit point, then the result holds in the output state until taken. Ready is
// low while an item is in work and while a result waits. Reset (rst,
// synchronous) restores the configuration and the state and clears the best
// hits.
`timescale 1ns / 1ps
`default_nettype none
module nearest_ray_box_sphere_hit_unit (
  input  wire logic clk,
  input  wire logic rst,
  nrbs_if.sink      in_item,
  nrbs_if.source    out_hit,
  input  wire logic cfg_we,
  input  wire logic [nrbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nrbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nrbs_pkg::*;

  // configuration
  logic signed [31:0] org [3];
  logic signed [17:0] dir [3];
  logic [30:0] radius;
  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0; org[1] <= '0; org[2] <= '0;
      dir[0] <= '0; dir[1] <= '0; dir[2] <= 18'sd65536;
      radius <= 31'd29491;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OX: org[0] <= cfg_data;
        REG_OY: org[1] <= cfg_data;
        REG_OZ: org[2] <= cfg_data;
        REG_DX: dir[0] <= cfg_data[17:0];
        REG_DY: dir[1] <= cfg_data[17:0];
        REG_DZ: dir[2] <= cfg_data[17:0];
        REG_RAD: radius <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  nrbs_state_t state, state_next;
  nrbs_in_t    item;
  logic [1:0]  axis;
  logic        second;
  logic        miss;
  logic signed [51:0] tmin, tmax, t1;
  logic        hit;
  logic [30:0] hit_dist;
  // sphere values
  logic signed [32:0] m [3];
  logic signed [67:0] bsum;
  logic [67:0] mm;
  logic [127:0] disc;
  logic [61:0] rr;
  // discriminant terms at the root scale
  logic [127:0] pos_w, neg_w, sq_in;
  // best hits
  logic        box_seen, sphere_seen;
  logic [30:0] best_box_distance, best_sphere_distance;
  logic [31:0] best_box_id, best_sphere_id;
  logic [30:0] near;
  logic signed [49:0] prod [3];
  nrbs_out_t   res;
  logic        out_valid;

  // shared divider and root units
  logic div_start, div_done, sq_start, sq_done;
  logic signed [49:0] div_num;
  logic signed [50:0] div_q;
  logic [63:0] root;
  logic signed [31:0] bnd_lo, bnd_hi, o_a;
  logic signed [17:0] d_a;

  always_comb begin
    o_a = org[axis];
    d_a = dir[axis];
    unique case (axis)
      2'd0: begin bnd_lo = item.box_min_x; bnd_hi = item.box_max_x; end
      2'd1: begin bnd_lo = item.box_min_y; bnd_hi = item.box_max_y; end
      default: begin bnd_lo = item.box_min_z; bnd_hi = item.box_max_z; end
    endcase
    div_num = 50'((second ? 33'(bnd_hi) - 33'(o_a) : 33'(bnd_lo) - 33'(o_a)))
              <<< FRAC_BITS;
  end

  // b*b has been summed into disc; add r*r and take away m.m, both scaled
  always_comb begin
    pos_w = disc + (128'(rr) << (2 * FRAC_BITS));
    neg_w = 128'(mm) << (2 * FRAC_BITS);
    sq_in = pos_w - neg_w;
  end

  nrbs_divider u_div (.clk, .rst, .start(div_start), .dividend(div_num),
                      .divisor(d_a), .done(div_done), .quotient(div_q));
  nrbs_sqrt u_sqrt (.clk, .rst, .start(sq_start), .radicand(sq_in),
                    .done(sq_done), .root(root));

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    sq_start  = 1'b0;
    unique case (state)
      S_IDLE:   if (in_item.valid && in_item.ready)
                  state_next = in_item.data.kind ? S_SM : S_BAX;
      S_BAX:    if (axis == 2'd3 || miss) state_next = S_BDONE;
                else if (d_a == 0) state_next = S_BNEXT;
                else begin div_start = 1'b1; state_next = S_BDIV_W; end
      S_BDIV:   begin div_start = 1'b1; state_next = S_BDIV_W; end
      S_BDIV_W: if (div_done) state_next = second ? S_BNEXT : S_BDIV;
      S_BNEXT:  state_next = S_BAX;
      S_BDONE:  state_next = S_UPD;
      S_SM:     state_next = S_SMUL;
      S_SMUL:   if (axis == 2'd2) state_next = S_SRR;
      S_SRR:    state_next = S_SCHK;
      // three partial products of b*b, one a cycle
      S_SCHK:   if (axis == 2'd2) state_next = S_SSQ;
      S_SSQ:    if (miss || pos_w < neg_w) state_next = S_UPD;
                else begin sq_start = 1'b1; state_next = S_SSQ_W; end
      S_SSQ_W:  if (sq_done) state_next = S_SDONE;
      S_SDONE:  state_next = S_UPD;
      S_UPD:    state_next = item.last_item ? S_PT : S_IDLE;
      S_PT:     state_next = S_PT_W;
      S_PT_W:   state_next = S_OUT;
      S_OUT:    if (out_hit.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  logic signed [51:0] lo_t, hi_t;
  logic signed [68:0] negb_s;
  logic [67:0] bmag;
  always_comb begin
    lo_t = (t1 > 52'(div_q)) ? 52'(div_q) : t1;
    hi_t = (t1 > 52'(div_q)) ? t1 : 52'(div_q);
    negb_s = -69'(bsum) - 69'($signed({1'b0, root}));
    bmag = bsum[67] ? 68'(-bsum) : 68'(bsum);
    near = !box_seen ? best_sphere_distance :
           (sphere_seen && best_sphere_distance < best_box_distance) ?
           best_sphere_distance : best_box_distance;
  end

  logic [67:0] sq_m;
  always_comb sq_m = 68'(m[axis] * m[axis]);

  // |b| stays below 2^52: split it into two 26-bit halves
  logic [25:0]  bb_a, bb_b;
  logic [51:0]  bb_prod;
  logic [127:0] bb_pp;
  always_comb begin
    bb_a = (axis == 2'd2) ? bmag[51:26] : bmag[25:0];
    bb_b = (axis == 2'd0) ? bmag[25:0] : bmag[51:26];
    bb_prod = bb_a * bb_b;
    case (axis)
      2'd0:    bb_pp = 128'(bb_prod);
      2'd1:    bb_pp = 128'(bb_prod) << 27;
      default: bb_pp = 128'(bb_prod) << 52;
    endcase
  end

  function automatic logic signed [31:0] sat32(input logic any,
      input logic signed [31:0] o, input logic signed [49:0] p);
    logic signed [50:0] s;
    s = 51'(o) + 51'(p >>> FRAC_BITS);
    if (!any) return '0;
    if (s > 51'sd2147483647) return 32'sh7FFF_FFFF;
    if (s < -51'sd2147483648) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      box_seen <= 1'b0;
      sphere_seen <= 1'b0;
      best_box_distance <= DIST_MAX;
      best_sphere_distance <= DIST_MAX;
      best_box_id <= '0;
      best_sphere_id <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_item.valid && in_item.ready) begin
          item <= in_item.data; axis <= '0; second <= 1'b0; miss <= 1'b0;
          tmin <= '0; tmax <= {1'b0, {51{1'b1}}};
          bsum <= '0; mm <= '0; hit <= 1'b0;
        end
        S_BAX: if (axis != 2'd3 && !miss && d_a == 0)
          miss <= (o_a < bnd_lo) || (o_a > bnd_hi);
        S_BDIV_W: if (div_done) begin
          if (!second) begin
            t1 <= 52'(div_q);
            second <= 1'b1;
          end else begin
            if (lo_t > tmin) tmin <= lo_t;
            if (hi_t < tmax) tmax <= hi_t;
            if ((lo_t > tmin ? lo_t : tmin) > (hi_t < tmax ? hi_t : tmax))
              miss <= 1'b1;
          end
        end
        S_BNEXT: begin axis <= axis + 2'd1; second <= 1'b0; end
        S_BDONE: begin
          hit <= !miss;
          hit_dist <= (tmin <= 0) ? '0 :
                      (tmin > 52'(DIST_MAX)) ? DIST_MAX : tmin[30:0];
        end
        S_SM: begin
          m[0] <= 33'(org[0]) - 33'(item.sphere_centre_x);
          m[1] <= 33'(org[1]) - 33'(item.sphere_centre_y);
          m[2] <= 33'(org[2]) - 33'(item.sphere_centre_z);
        end
        S_SMUL: begin
          bsum <= bsum + 68'(m[axis] * dir[axis]);
          mm   <= mm + sq_m;
          axis <= axis + 2'd1;
        end
        S_SRR: begin
          rr <= radius * radius;
          disc <= '0;
          axis <= '0;
        end
        S_SCHK: begin
          miss <= (mm > 68'(rr)) && (bsum > 0);
          disc <= disc + bb_pp;
          axis <= axis + 2'd1;
        end
        S_SSQ: if (!miss && pos_w < neg_w) miss <= 1'b1;
        S_SSQ_W: if (miss) hit <= 1'b0;
        S_SDONE: begin
          hit <= !miss;
          hit_dist <= (negb_s <= 0) ? '0 :
                      ((negb_s >>> FRAC_BITS) > 69'(DIST_MAX)) ? DIST_MAX :
                      31'(negb_s >>> FRAC_BITS);
        end
        S_UPD: begin
          if (!item.kind && hit && (!box_seen || hit_dist < best_box_distance)) begin
            box_seen <= 1'b1; best_box_distance <= hit_dist;
            best_box_id <= item.item_id;
          end
          if (item.kind && hit && !miss &&
              (!sphere_seen || hit_dist < best_sphere_distance)) begin
            sphere_seen <= 1'b1; best_sphere_distance <= hit_dist;
            best_sphere_id <= item.item_id;
          end
        end
        S_PT: for (int i = 0; i < 3; i++) prod[i] <= 50'(dir[i] * $signed({1'b0, near}));
        S_PT_W: begin
          res.box_found <= box_seen;
          res.box_distance <= box_seen ? best_box_distance : '0;
          res.box_id <= box_seen ? best_box_id : '0;
          res.sphere_found <= sphere_seen;
          res.sphere_distance <= sphere_seen ? best_sphere_distance : '0;
          res.sphere_id <= sphere_seen ? best_sphere_id : '0;
          res.point_x <= sat32(box_seen || sphere_seen, org[0], prod[0]);
          res.point_y <= sat32(box_seen || sphere_seen, org[1], prod[1]);
          res.point_z <= sat32(box_seen || sphere_seen, org[2], prod[2]);
          out_valid <= 1'b1;
          box_seen <= 1'b0; sphere_seen <= 1'b0;
          best_box_distance <= DIST_MAX; best_sphere_distance <= DIST_MAX;
          best_box_id <= '0; best_sphere_id <= '0;
        end
        S_OUT: if (out_hit.ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  assign in_item.ready = (state == S_IDLE);
  assign out_hit.valid = out_valid;
  assign out_hit.data  = res;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_hit.valid |-> !in_item.ready) else $error("input taken with result pending");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_hit.valid |-> state == S_OUT) else $error("result valid outside output state");
  a_found_dist: assert property (@(posedge clk) disable iff (rst)
    (out_hit.valid && !out_hit.data.box_found) |-> out_hit.data.box_distance == 0)
    else $error("box distance without hit");
endmodule
`default_nettype wire

[hdl/nrbs_divider.sv]
// Restoring signed divider, one quotient bit a cycle, truncates toward zero.
// Depends on nrbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrbs_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic signed [49:0] dividend,
  input  wire logic signed [17:0] divisor,
  output logic             done,
  output logic signed [50:0] quotient
);
  import nrbs_pkg::*;
  logic [49:0] num;
  logic [17:0] den;
  logic [18:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  logic [19:0] trial;
  always_comb trial = {rem, num[49]} - {2'b0, den};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd50;
        num  <= dividend[49] ? 50'(-dividend) : dividend;
        den  <= divisor[17] ? 18'(-divisor) : divisor;
        neg  <= dividend[49] ^ divisor[17];
        rem  <= '0;
      end else if (busy) begin
        if (!trial[19]) rem <= trial[18:0];
        else rem <= {rem[17:0], num[49]};
        num <= {num[48:0], ~trial[19]};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  always_comb quotient = neg ? -$signed({1'b0, num}) : $signed({1'b0, num});
endmodule
`default_nettype wire

[hdl/nrbs_sqrt.sv]
// Bit-serial integer square root of a 128-bit value, one result bit a cycle.
// Depends on nrbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrbs_sqrt (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [127:0] radicand,
  output logic              done,
  output logic [63:0]       root
);
  import nrbs_pkg::*;
  logic [127:0] x;
  logic [65:0]  rem;
  logic [6:0]   cnt;
  logic         busy;
  logic [67:0]  trial;
  logic [65:0]  shifted;
  always_comb begin
    shifted = {rem[63:0], x[127:126]};
    trial = {2'b0, shifted} - {2'b0, root, 2'b01};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        x    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        x <= {x[125:0], 2'b00};
        if (!trial[67]) begin
          rem  <= trial[65:0];
          root <= {root[62:0], 1'b1};
        end else begin
          rem  <= shifted;
          root <= {root[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire
